/* src/picd_pkg.sv */
package picd_pkg;

    // Field widths fixed by the beat formats
    localparam int unsigned EDGE_TIME_W = 16;
    localparam int unsigned BASE_W      = 16;
    localparam int unsigned CODE_W      = 4;
    localparam int unsigned LEVEL_W     = 12;

    // Default timer width
    localparam int unsigned DEF_TIME_WIDTH = 16;

    // Timing constants in timer ticks: the base_time reset value, then offsets above base_time
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd100;
    localparam int unsigned HEADER_GAP  = 400;
    localparam int unsigned FIRST_STEP  = 75;
    localparam int unsigned NUM_STEPS   = 7;
    localparam int unsigned CODE_STEPS [NUM_STEPS] = '{150, 250, 350, 450, 550, 650, 750};

    // Code values and DAC levels
    localparam logic [CODE_W-1:0]  CODE_NONE  = 4'd0;
    localparam logic [CODE_W-1:0]  CODE_FIRST = 4'd1;
    localparam logic [CODE_W-1:0]  CODE_MAX   = 4'd8;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 12'd4095;

    typedef struct packed {
        logic [EDGE_TIME_W-1:0] edge_time;
        logic                   is_falling;
    } t_in_beat;

    typedef struct packed {
        logic [CODE_W-1:0]  decoded_code;
        logic [LEVEL_W-1:0] dac_level;
    } t_out_beat;

    // Interval classification handed from the quantizer to the control
    typedef struct packed {
        logic              long_gap;
        logic              first_hit;
        logic [CODE_W-1:0] code;
    } t_gap_flags;

    // 512 per code step; the top code saturates at full scale
    function automatic logic [LEVEL_W-1:0] level_of(input logic [CODE_W-1:0] code);
        logic [LEVEL_W-1:0] lvl;
        if (code >= CODE_MAX) begin
            lvl = LEVEL_FULL;
        end else begin
            lvl = {code[2:0], 9'b0};
        end
        return lvl;
    endfunction

endpackage

/* src/picd_quantize.sv */
module picd_quantize #(
    parameter int unsigned TIME_WIDTH = picd_pkg::DEF_TIME_WIDTH
) (
    input  logic [TIME_WIDTH-1:0]         i_dt,
    input  logic [picd_pkg::BASE_W-1:0]   i_base,
    output picd_pkg::t_gap_flags          o_flags
);

    // Wide enough that base plus the largest step never wraps
    localparam int unsigned CMP_W =
        ((TIME_WIDTH > picd_pkg::BASE_W) ? TIME_WIDTH : picd_pkg::BASE_W) + 1;

    logic [CMP_W-1:0] dt_ext;
    logic [CMP_W-1:0] base_ext;
    logic [picd_pkg::NUM_STEPS-1:0] reach;
    logic [picd_pkg::CODE_W-1:0] code;

    assign dt_ext   = CMP_W'(i_dt);
    assign base_ext = CMP_W'(i_base);

    // Independent compare per threshold
    always_comb begin
        for (int i = 0; i < picd_pkg::NUM_STEPS; i++) begin
            reach[i] = dt_ext >= (base_ext + CMP_W'(picd_pkg::CODE_STEPS[i]));
        end
    end

    // Highest threshold reached sets the code
    always_comb begin
        code = picd_pkg::CODE_FIRST;
        for (int i = 0; i < picd_pkg::NUM_STEPS; i++) begin
            if (reach[i]) begin
                code = picd_pkg::CODE_W'(i + 2);
            end
        end
    end

    assign o_flags.long_gap  = dt_ext >= (base_ext + CMP_W'(picd_pkg::HEADER_GAP));
    assign o_flags.first_hit = dt_ext >= (base_ext + CMP_W'(picd_pkg::FIRST_STEP));
    assign o_flags.code      = code;

endmodule

/* src/pulse_interval_code_decoder.sv */
// Pulse-interval code decoder. Each input beat is one edge event: a timer
// count and its polarity. Every edge records its time; falling edges decode
// the interval since the previous edge (taken modulo 2^TIME_WIDTH). A gap of
// at least base_time+400 ticks marks a header, the next interval is quantized
// to a code 1..8 against thresholds base_time+75 .. base_time+750 (shorter than
// base_time+75 drops the frame), and a following long gap closes the frame and
// emits one result beat: the code and its DAC level (512 per code, 4095 for
// code 8). Throughput is one edge per clock. The input stalls only while a
// result beat waits stalled at the output and another edge is already held in
// the input register. An accepted edge is first loaded into the input register;
// then, once the held beat can advance, it runs the subtract and compare ladder
// into the decoder state and the result register, from which the result beat is
// taken. base_time resets to 100 and may be rewritten only while the block is
// idle.
module pulse_interval_code_decoder #(
    parameter int unsigned TIME_WIDTH = picd_pkg::DEF_TIME_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // edge event channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  picd_pkg::t_in_beat          i_in_data,
    // decoded frame channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output picd_pkg::t_out_beat         o_out_data,
    // base_time register
    input  logic                        i_cfg_wr_en,
    input  logic [picd_pkg::BASE_W-1:0] i_cfg_wr_data
);

    // Input register
    logic                r_in_valid;
    picd_pkg::t_in_beat  r_in;

    // Decoder state
    logic [picd_pkg::BASE_W-1:0] r_base;
    logic [TIME_WIDTH-1:0]       r_prev_time;
    logic                        r_header;
    logic [picd_pkg::CODE_W-1:0] r_pending;

    // Result register
    logic                r_out_valid;
    picd_pkg::t_out_beat r_out;

    logic                        advance;
    logic [TIME_WIDTH-1:0]       now;
    logic [TIME_WIDTH-1:0]       dt;
    picd_pkg::t_gap_flags        flags;
    logic                        n_header;
    logic [picd_pkg::CODE_W-1:0] n_pending;
    logic                        emit;

    // The held beat moves on whenever the result slot is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Reduce the timestamp to the timer width, interval wraps naturally.
    assign now = TIME_WIDTH'(r_in.edge_time);
    assign dt  = now - r_prev_time;

    picd_quantize #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_quantize (
        .i_dt    (dt),
        .i_base  (r_base),
        .o_flags (flags)
    );

    // Frame tracking: header -> code -> closing gap.
    always_comb begin
        n_header  = r_header;
        n_pending = r_pending;
        emit      = 1'b0;
        if (r_in.is_falling) begin
            priority if (!r_header) begin
                // hunt for a header gap
                if (flags.long_gap) begin
                    n_header  = 1'b1;
                    n_pending = picd_pkg::CODE_NONE;
                end
            end else if (r_pending != picd_pkg::CODE_NONE) begin
                // closing gap: emit if long, restart the hunt either way
                emit      = flags.long_gap;
                n_header  = 1'b0;
                n_pending = picd_pkg::CODE_NONE;
            end else if (flags.first_hit) begin
                // latch the quantized code
                n_pending = flags.code;
            end else begin
                // too short to be a code: drop the frame
                n_header  = 1'b0;
                n_pending = picd_pkg::CODE_NONE;
            end
        end
    end

    // Input register: load whenever not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= picd_pkg::BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    // Decoder state: advance once per processed edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_header    <= 1'b0;
            r_pending   <= picd_pkg::CODE_NONE;
        end else if (advance) begin
            r_prev_time <= now;
            r_header    <= n_header;
            r_pending   <= n_pending;
        end
    end

    // Result register: fill on emit, drain when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out.decoded_code <= r_pending;
            r_out.dac_level    <= picd_pkg::level_of(r_pending);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/picd_checker.sv */
module picd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input picd_pkg::t_out_beat         o_out_data
);

    // Held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Level always matches the code
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.dac_level == picd_pkg::level_of(o_out_data.decoded_code))
        else $error("dac level does not match code");

    // Only real codes leave the block
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.decoded_code >= picd_pkg::CODE_FIRST &&
                        o_out_data.decoded_code <= picd_pkg::CODE_MAX)
        else $error("decoded code out of range");

    // Input side never stalls while the result side drains
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled with free result path");

    // Reset empties both registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind pulse_interval_code_decoder picd_checker u_picd_checker (.*);
